// ----- design/lohs_pkg.sv -----
// Shared codes and types for the link open handshake block.
package lohs_pkg;

    // Request codes carried by req_type
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Frame matcher state codes
    localparam logic [2:0] FS_IDLE  = 3'd0;
    localparam logic [2:0] FS_FLAG  = 3'd1;
    localparam logic [2:0] FS_ADDR  = 3'd2;
    localparam logic [2:0] FS_CTRL  = 3'd3;
    localparam logic [2:0] FS_CHECK = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROLE        = 3'd0;
    localparam logic [2:0] CFG_FLAG        = 3'd1;
    localparam logic [2:0] CFG_CMD_ADDR    = 3'd2;
    localparam logic [2:0] CFG_SET_CTRL    = 3'd3;
    localparam logic [2:0] CFG_ANS_ADDR    = 3'd4;
    localparam logic [2:0] CFG_UA_CTRL     = 3'd5;
    localparam logic [2:0] CFG_TIMEOUT     = 3'd6;
    localparam logic [2:0] CFG_MAX_ATTEMPT = 3'd7;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    // Matcher inputs: frame pattern to look for
    typedef struct packed {
        logic [7:0] flag;
        logic [7:0] addr;
        logic [7:0] ctrl;
    } frame_pattern_t;

    // Matcher outputs
    typedef struct packed {
        logic [2:0] next_state;
        logic       closed;
    } match_result_t;

endpackage

// ----- design/link_open_handshake_core.sv -----
// Top level of the link open handshake: SET/UA setup over a byte stream.
// Path: an accepted input item is held in the input register, then its
//   result item is held in the result register until it leaves.
// Throughput: one item per cycle while out_stall does not hold the result; the
//   single-pass update of the handshake state between the two registers sets this figure.
// Reset: rst_n clears all handshake state and loads configuration defaults.
module link_open_handshake_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [lohs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lohs_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic [7:0]                          rx_byte,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                send_set,
    output logic                                send_ua,
    output logic                                established,
    output logic                                gave_up,
    output logic [3:0]                          attempt_count
);
    import lohs_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        role_rx_reg;
    logic [7:0]  flag_reg;
    logic [7:0]  cmd_addr_reg;
    logic [7:0]  set_ctrl_reg;
    logic [7:0]  ans_addr_reg;
    logic [7:0]  ua_ctrl_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  max_attempts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_rx_reg      <= 1'b0;
            flag_reg         <= 8'd126;
            cmd_addr_reg     <= 8'd3;
            set_ctrl_reg     <= 8'd3;
            ans_addr_reg     <= 8'd1;
            ua_ctrl_reg      <= 8'd7;
            timeout_reg      <= 16'd3;
            max_attempts_reg <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROLE:        role_rx_reg      <= cfg_data[0];
                CFG_FLAG:        flag_reg         <= cfg_data[7:0];
                CFG_CMD_ADDR:    cmd_addr_reg     <= cfg_data[7:0];
                CFG_SET_CTRL:    set_ctrl_reg     <= cfg_data[7:0];
                CFG_ANS_ADDR:    ans_addr_reg     <= cfg_data[7:0];
                CFG_UA_CTRL:     ua_ctrl_reg      <= cfg_data[7:0];
                CFG_TIMEOUT:     timeout_reg      <= cfg_data[15:0];
                CFG_MAX_ATTEMPT: max_attempts_reg <= cfg_data[3:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic       s1_valid_reg;
    logic [1:0] s1_req_reg;
    logic [7:0] s1_byte_reg;
    logic       advance;
    logic       in_take;

    // Move the held item into the result register whenever that register
    // is empty or is being drained this cycle.
    assign advance  = s1_valid_reg && (!out_valid || !out_stall);
    // Stall only when both the input register and the result are stuck.
    assign in_stall = s1_valid_reg && out_valid && out_stall;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_req_reg  <= req_type;
            s1_byte_reg <= rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Handshake state
    // ---------------------------------------------------------------
    logic [2:0]  frame_state_reg, frame_state_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [3:0]  timeouts_reg, timeouts_next;
    logic        armed_reg, armed_next;
    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic        failed_reg, failed_next;
    logic        send_set_next, send_ua_next;

    frame_pattern_t pattern;
    match_result_t  match;
    logic           tx_role;
    logic [15:0]    tick_inc;
    logic [3:0]     timeouts_inc;

    assign tx_role      = !role_rx_reg;
    assign tick_inc     = tick_count_reg + 16'd1;
    assign timeouts_inc = timeouts_reg + 4'd1;

    // Transmitter listens for UA, receiver listens for SET.
    assign pattern.flag = flag_reg;
    assign pattern.addr = tx_role ? ans_addr_reg : cmd_addr_reg;
    assign pattern.ctrl = tx_role ? ua_ctrl_reg : set_ctrl_reg;

    lohs_frame_match u_match (
        .state   (frame_state_reg),
        .rx_byte (s1_byte_reg),
        .pattern (pattern),
        .result  (match)
    );

    always_comb
    begin
        frame_state_next = frame_state_reg;
        tick_count_next  = tick_count_reg;
        timeouts_next    = timeouts_reg;
        armed_next       = armed_reg;
        active_next      = active_reg;
        done_next        = done_reg;
        failed_next      = failed_reg;
        send_set_next    = 1'b0;
        send_ua_next     = 1'b0;

        unique case (s1_req_reg)
            REQ_START:
            begin
                // start, or restart a running handshake
                active_next      = 1'b1;
                done_next        = 1'b0;
                failed_next      = 1'b0;
                timeouts_next    = 4'd0;
                tick_count_next  = 16'd0;
                frame_state_next = FS_IDLE;
                armed_next       = tx_role;
                send_set_next    = tx_role;
            end
            REQ_TICK:
            begin
                if (tx_role && active_reg && armed_reg)
                begin
                    tick_count_next = tick_inc;
                    // a zero timeout expires on the first tick
                    if (tick_inc >= timeout_reg)
                    begin
                        tick_count_next = 16'd0;
                        timeouts_next   = timeouts_inc;
                        if (timeouts_inc >= max_attempts_reg)
                        begin
                            failed_next = 1'b1;
                            active_next = 1'b0;
                            armed_next  = 1'b0;
                        end
                        else
                        begin
                            send_set_next = 1'b1;
                        end
                    end
                end
            end
            REQ_BYTE:
            begin
                if (active_reg)
                begin
                    frame_state_next = match.next_state;
                    if (match.closed)
                    begin
                        done_next       = 1'b1;
                        active_next     = 1'b0;
                        armed_next      = 1'b0;
                        tick_count_next = 16'd0;
                        send_ua_next    = !tx_role;
                    end
                end
            end
            default:
            begin
                // unused request code: report status only
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_state_reg <= FS_IDLE;
            tick_count_reg  <= 16'd0;
            timeouts_reg    <= 4'd0;
            armed_reg       <= 1'b0;
            active_reg      <= 1'b0;
            done_reg        <= 1'b0;
            failed_reg      <= 1'b0;
        end
        else if (advance)
        begin
            frame_state_reg <= frame_state_next;
            tick_count_reg  <= tick_count_next;
            timeouts_reg    <= timeouts_next;
            armed_reg       <= armed_next;
            active_reg      <= active_next;
            done_reg        <= done_next;
            failed_reg      <= failed_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic       out_valid_reg;
    logic       send_set_reg;
    logic       send_ua_reg;
    logic       established_reg;
    logic       gave_up_reg;
    logic [3:0] attempt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            // drop the item once it has been taken
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            send_set_reg    <= send_set_next;
            send_ua_reg     <= send_ua_next;
            established_reg <= done_next;
            gave_up_reg     <= failed_next;
            attempt_reg     <= timeouts_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_set      = send_set_reg;
    assign send_ua       = send_ua_reg;
    assign established   = established_reg;
    assign gave_up       = gave_up_reg;
    assign attempt_count = attempt_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A running handshake has neither succeeded nor failed.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (!done_reg && !failed_reg))
        else $error("active handshake carries a final status");

    // Success and failure exclude each other in every result item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(established && gave_up))
        else $error("result reports both established and gave_up");

    // One role sends only its own frame type.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(send_set && send_ua))
        else $error("result asks for SET and UA together");

    // An empty input register never stalls the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    // The timer runs only while a transmitter handshake is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> active_reg)
        else $error("timer armed outside an active handshake");

endmodule

// ----- design/lohs_frame_match.sv -----
// Byte-wise frame header matcher: flag, address, control, check, flag.
module lohs_frame_match (
    input  logic [2:0]              state,
    input  logic [7:0]              rx_byte,
    input  lohs_pkg::frame_pattern_t pattern,
    output lohs_pkg::match_result_t  result
);
    import lohs_pkg::*;

    logic [7:0] check_byte;
    logic       is_flag;

    assign check_byte = pattern.addr ^ pattern.ctrl;
    assign is_flag    = (rx_byte == pattern.flag);

    always_comb
    begin
        result.closed     = 1'b0;
        result.next_state = FS_IDLE;
        unique case (state)
            FS_IDLE:
            begin
                result.next_state = is_flag ? FS_FLAG : FS_IDLE;
            end
            FS_FLAG:
            begin
                result.next_state = (rx_byte == pattern.addr) ? FS_ADDR :
                                    (is_flag ? FS_FLAG : FS_IDLE);
            end
            FS_ADDR:
            begin
                result.next_state = (rx_byte == pattern.ctrl) ? FS_CTRL :
                                    (is_flag ? FS_FLAG : FS_IDLE);
            end
            FS_CTRL:
            begin
                // check byte wins over a flag in this position
                result.next_state = (rx_byte == check_byte) ? FS_CHECK :
                                    (is_flag ? FS_FLAG : FS_IDLE);
            end
            FS_CHECK:
            begin
                // only the closing flag completes the frame
                result.next_state = FS_IDLE;
                result.closed     = is_flag;
            end
            default:
            begin
                result.next_state = FS_IDLE;
            end
        endcase
    end

endmodule
